// ===== rtl/core/gcl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_pkg
// Shared constants, types and the microcode table of the gcd/lcm unit.
// ----------------------------------------------------------------------------
package gcl_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int FIELD_BITS   = 31;
  localparam int GCD_BITS     = 31;
  localparam int LCM_BITS     = 62;

  localparam int PROD_BITS  = 2 * OPERAND_BITS;
  localparam int SHIFT_BITS = $clog2(OPERAND_BITS);
  localparam int COUNT_BITS = $clog2(OPERAND_BITS + 1);

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_ZCHK     = 4'd1;
  localparam step_t STEP_TWOS     = 4'd2;
  localparam step_t STEP_XODD     = 4'd3;
  localparam step_t STEP_REDUCE   = 4'd4;
  localparam step_t STEP_SCALE    = 4'd5;
  localparam step_t STEP_DIV_INIT = 4'd6;
  localparam step_t STEP_DIV      = 4'd7;
  localparam step_t STEP_MUL_INIT = 4'd8;
  localparam step_t STEP_MUL      = 4'd9;
  localparam step_t STEP_EMIT     = 4'd10;
  localparam step_t STEP_ZERO     = 4'd11;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_HALVE_BOTH,
    OP_HALVE_X,
    OP_REDUCE,
    OP_SCALE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_INIT,
    OP_MUL_STEP,
    OP_EMIT,
    OP_ZERO_RESULT
  } op_t;

  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_ANY_ZERO,
    COND_BOTH_EVEN,
    COND_X_EVEN,
    COND_Y_NONZERO,
    COND_K_NONZERO,
    COND_CNT_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t jump;
    step_t next;
  } ucode_t;

  typedef struct packed {
    op_t op;
  } gcl_ctrl_t;

  typedef struct packed {
    logic no_input;
    logic any_zero;
    logic both_even;
    logic x_even;
    logic y_nonzero;
    logic k_nonzero;
    logic cnt_more;
    logic out_busy;
  } gcl_flags_t;

  function automatic ucode_t gcl_ucode(input step_t step);
    ucode_t w;
    case (step)
      STEP_IDLE:     w = '{OP_LOAD,        COND_NO_INPUT,  STEP_IDLE,   STEP_ZCHK};
      STEP_ZCHK:     w = '{OP_NOP,         COND_ANY_ZERO,  STEP_ZERO,   STEP_TWOS};
      STEP_TWOS:     w = '{OP_HALVE_BOTH,  COND_BOTH_EVEN, STEP_TWOS,   STEP_XODD};
      STEP_XODD:     w = '{OP_HALVE_X,     COND_X_EVEN,    STEP_XODD,   STEP_REDUCE};
      STEP_REDUCE:   w = '{OP_REDUCE,      COND_Y_NONZERO, STEP_REDUCE, STEP_SCALE};
      STEP_SCALE:    w = '{OP_SCALE,       COND_K_NONZERO, STEP_SCALE,  STEP_DIV_INIT};
      STEP_DIV_INIT: w = '{OP_DIV_INIT,    COND_NEVER,     STEP_IDLE,   STEP_DIV};
      STEP_DIV:      w = '{OP_DIV_STEP,    COND_CNT_MORE,  STEP_DIV,    STEP_MUL_INIT};
      STEP_MUL_INIT: w = '{OP_MUL_INIT,    COND_NEVER,     STEP_IDLE,   STEP_MUL};
      STEP_MUL:      w = '{OP_MUL_STEP,    COND_CNT_MORE,  STEP_MUL,    STEP_EMIT};
      STEP_EMIT:     w = '{OP_EMIT,        COND_OUT_BUSY,  STEP_EMIT,   STEP_IDLE};
      STEP_ZERO:     w = '{OP_ZERO_RESULT, COND_ALWAYS,    STEP_EMIT,   STEP_IDLE};
      default:       w = '{OP_NOP,         COND_NEVER,     STEP_IDLE,   STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gcl_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_in_if
// Operand channel: one word carries the two operands.
// ----------------------------------------------------------------------------
interface gcl_in_if import gcl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FIELD_BITS-1:0] first_value;
  logic [FIELD_BITS-1:0] second_value;

  modport source (output valid, output first_value, output second_value, input ready);
  modport sink   (input valid, input first_value, input second_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gcl_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_out_if
// Result channel: one word carries the gcd and the lcm.
// ----------------------------------------------------------------------------
interface gcl_out_if import gcl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [GCD_BITS-1:0] gcd_value;
  logic [LCM_BITS-1:0] lcm_value;

  modport source (output valid, output gcd_value, output lcm_value, input ready);
  modport sink   (input valid, input gcd_value, input lcm_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gcd_lcm_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// Greatest common divisor and least common multiple of two operands.
//
// Operands arrive on a valid/ready channel, one word holding first_value
// and second_value; results leave on a valid/ready channel, one word
// holding gcd_value and lcm_value. One result word per operand word.
// A microcode sequencer steps a small datapath: binary gcd (one halve or
// subtract per cycle), restore of the common power of two, a 31-step
// shift-subtract divide of first_value by the gcd, and a 31-step
// shift-add multiply by second_value.
// An item with a zero operand skips the gcd, divide and multiply steps.
// One item is in work at a time and the next word is taken the cycle
// after emit. Reset clears the step counter and the result valid. A
// finished word waits in the output register; a new operand word is
// taken meanwhile, and the emit step holds only while the previous word
// is still not taken.
// ----------------------------------------------------------------------------
module gcd_lcm_unit import gcl_pkg::*; (
  input  wire       clk,
  input  wire       rst,
  gcl_in_if.sink    operands,
  gcl_out_if.source results
);

  gcl_ctrl_t  ctrl;
  gcl_flags_t flags;

  gcl_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  gcl_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .flags    (flags),
    .operands (operands),
    .results  (results)
  );

endmodule
`default_nettype wire

// ===== rtl/core/gcl_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module gcl_sequencer import gcl_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  gcl_flags_t flags,
  output gcl_ctrl_t  ctrl
);

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   taken;

  assign word    = gcl_ucode(step);
  assign ctrl.op = word.op;

  always_comb begin
    case (word.cond)
      COND_NEVER:     taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_INPUT:  taken = flags.no_input;
      COND_ANY_ZERO:  taken = flags.any_zero;
      COND_BOTH_EVEN: taken = flags.both_even;
      COND_X_EVEN:    taken = flags.x_even;
      COND_Y_NONZERO: taken = flags.y_nonzero;
      COND_K_NONZERO: taken = flags.k_nonzero;
      COND_CNT_MORE:  taken = flags.cnt_more;
      COND_OUT_BUSY:  taken = flags.out_busy;
      default:        taken = 1'b0;
    endcase
  end

  assign step_next = taken ? word.jump : word.next;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  a_emit_returns: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_EMIT && !flags.out_busy) |=> step == STEP_IDLE)
    else $error("emit step did not return to idle");

  a_zero_to_emit: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_ZCHK && flags.any_zero) |=> ##1 step == STEP_EMIT)
    else $error("zero operand path did not reach emit");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_IDLE && flags.no_input) |=> step == STEP_IDLE)
    else $error("left idle without an operand word");

endmodule
`default_nettype wire

// ===== rtl/core/gcl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcl_datapath
// Binary gcd, shift-subtract divide and shift-add multiply registers,
// plus the result register.
// ----------------------------------------------------------------------------
module gcl_datapath import gcl_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  input  gcl_ctrl_t    ctrl,
  output gcl_flags_t   flags,
  gcl_in_if.sink       operands,
  gcl_out_if.source    results
);

  logic [OPERAND_BITS-1:0] x;
  logic [OPERAND_BITS-1:0] y;
  logic [OPERAND_BITS-1:0] a0;
  logic [OPERAND_BITS-1:0] b0;
  logic [OPERAND_BITS-1:0] q;
  logic [OPERAND_BITS-1:0] r;
  logic [PROD_BITS-1:0]    p;
  logic [SHIFT_BITS-1:0]   k;
  logic [COUNT_BITS-1:0]   cnt;
  logic                    out_valid;
  logic [GCD_BITS-1:0]     gcd_out;
  logic [LCM_BITS-1:0]     lcm_out;

  logic [OPERAND_BITS-1:0] a_in;
  logic [OPERAND_BITS-1:0] b_in;
  logic                    x_gt;
  logic [OPERAND_BITS-1:0] diff;
  logic [OPERAND_BITS-1:0] small_xy;
  logic [OPERAND_BITS:0]   r_sh;
  logic [OPERAND_BITS:0]   r_sub;
  logic                    ge;
  logic [OPERAND_BITS-1:0] r_next;
  logic [OPERAND_BITS-1:0] q_div_next;
  logic [PROD_BITS-1:0]    p_next;
  logic                    in_fire;
  logic                    out_busy;
  logic                    emit;

  assign a_in = OPERAND_BITS'(operands.first_value);
  assign b_in = OPERAND_BITS'(operands.second_value);

  assign x_gt     = x > y;
  assign diff     = x_gt ? (x - y) : (y - x);
  assign small_xy = x_gt ? y : x;

  assign r_sh       = {r, q[OPERAND_BITS-1]};
  assign r_sub      = r_sh - {1'b0, x};
  assign ge         = !r_sub[OPERAND_BITS];
  assign r_next     = ge ? r_sub[OPERAND_BITS-1:0] : r_sh[OPERAND_BITS-1:0];
  assign q_div_next = {q[OPERAND_BITS-2:0], ge};

  assign p_next = {p[PROD_BITS-2:0], 1'b0} +
                  (q[OPERAND_BITS-1] ? PROD_BITS'(b0) : {PROD_BITS{1'b0}});

  assign operands.ready = (ctrl.op == OP_LOAD);
  assign in_fire        = operands.valid && operands.ready;
  assign out_busy       = out_valid && !results.ready;
  assign emit           = (ctrl.op == OP_EMIT) && !out_busy;

  assign flags.no_input  = !operands.valid;
  assign flags.any_zero  = (x == '0) || (y == '0);
  assign flags.both_even = !x[0] && !y[0];
  assign flags.x_even    = !x[0];
  assign flags.y_nonzero = (y != '0);
  assign flags.k_nonzero = (k != '0);
  assign flags.cnt_more  = (cnt != COUNT_BITS'(1));
  assign flags.out_busy  = out_busy;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_fire) begin
          x  <= a_in;
          y  <= b_in;
          a0 <= a_in;
          b0 <= b_in;
          k  <= '0;
        end
      end
      OP_HALVE_BOTH: begin
        if (!x[0] && !y[0]) begin
          x <= x >> 1;
          y <= y >> 1;
          k <= k + SHIFT_BITS'(1);
        end
      end
      OP_HALVE_X: begin
        if (!x[0]) begin
          x <= x >> 1;
        end
      end
      OP_REDUCE: begin
        if (y != '0) begin
          if (!y[0]) begin
            y <= y >> 1;
          end else begin
            x <= small_xy;
            y <= diff;
          end
        end
      end
      OP_SCALE: begin
        if (k != '0) begin
          x <= x << 1;
          k <= k - SHIFT_BITS'(1);
        end
      end
      OP_DIV_INIT: begin
        r   <= '0;
        q   <= a0;
        cnt <= COUNT_BITS'(OPERAND_BITS);
      end
      OP_DIV_STEP: begin
        r   <= r_next;
        q   <= q_div_next;
        cnt <= cnt - COUNT_BITS'(1);
      end
      OP_MUL_INIT: begin
        p   <= '0;
        cnt <= COUNT_BITS'(OPERAND_BITS);
      end
      OP_MUL_STEP: begin
        p   <= p_next;
        q   <= q << 1;
        cnt <= cnt - COUNT_BITS'(1);
      end
      OP_ZERO_RESULT: begin
        x <= x | y;
        p <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      gcd_out <= GCD_BITS'(x);
      lcm_out <= LCM_BITS'(p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid     = out_valid;
  assign results.gcd_value = gcd_out;
  assign results.lcm_value = lcm_out;

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("emitted word not presented");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_STEP) |-> (x != '0))
    else $error("divide step with zero divisor");

  a_div_init_count: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_DIV_INIT) |=> (cnt == COUNT_BITS'(OPERAND_BITS)))
    else $error("divide counter not loaded");

  a_x_odd_reduce: assert property (@(posedge clk) disable iff (rst)
    (ctrl.op == OP_REDUCE) |-> x[0])
    else $error("reduce step with even x");

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of gcd_lcm_unit: a table of edge cases (zero, equal and full-scale
// operands), then random operand pairs shaped toward shared factors, powers of
// two, multiples, small values, equal pairs and zeros. Every result word is
// compared with a gcd/lcm typed into the table or computed here by the remainder
// method, under random idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import gcl_pkg::*;

  localparam int CYCLE_LIMIT    = 800000;
  localparam int RANDOM_WORDS   = 1200;
  localparam int CALM_WORDS     = 200;
  localparam int MODE_SPAN      = 150;
  localparam int HOLD_AFTER     = 300;
  localparam int HOLD_CYCLES    = 2000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int DRAIN_LIMIT    = 20000;
  localparam int REPORT_LIMIT   = 10;
  localparam int DIRECTED_ROWS  = 21;

  localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

  typedef struct packed {
    logic [GCD_BITS-1:0] gcd_value;
    logic [LCM_BITS-1:0] lcm_value;
  } gcd_lcm_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] first_value;
    logic [FIELD_BITS-1:0] second_value;
    logic                  typed_in;
    gcd_lcm_t              sums;
  } case_row_t;

  typedef enum int {
    MIX_FULL,
    MIX_SHARED,
    MIX_TWOS,
    MIX_SMALL,
    MIX_ZERO,
    MIX_EQUAL,
    MIX_MULTIPLE
  } operand_mix_t;

  logic clk;
  logic rst;

  gcl_in_if  operand_ch ();
  gcl_out_if result_ch ();

  gcd_lcm_unit dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operand_ch),
    .results  (result_ch)
  );

  case_row_t directed_rows [DIRECTED_ROWS] = '{
    '{31'd0,          31'd0,          1'b1, '{31'd0,          62'd0}},
    '{31'd0,          31'd5,          1'b1, '{31'd5,          62'd0}},
    '{31'd7,          31'd0,          1'b1, '{31'd7,          62'd0}},
    '{FIELD_MAX,      31'd0,          1'b1, '{FIELD_MAX,      62'd0}},
    '{31'd0,          FIELD_MAX,      1'b1, '{FIELD_MAX,      62'd0}},
    '{31'd1,          31'd0,          1'b1, '{31'd1,          62'd0}},
    '{31'd1,          31'd1,          1'b1, '{31'd1,          62'd1}},
    '{FIELD_MAX,      FIELD_MAX,      1'b1, '{FIELD_MAX,      62'd2147483647}},
    '{31'd1,          FIELD_MAX,      1'b1, '{31'd1,          62'd2147483647}},
    '{FIELD_MAX,      31'd1,          1'b1, '{31'd1,          62'd2147483647}},
    '{31'h4000_0000,  31'h4000_0000,  1'b1, '{31'h4000_0000,  62'h4000_0000}},
    '{31'd123456,     31'd123456,     1'b1, '{31'd123456,     62'd123456}},
    '{31'd12,         31'd18,         1'b0, '{31'd0,          62'd0}},
    '{31'd48,         31'd180,        1'b0, '{31'd0,          62'd0}},
    '{31'h4000_0000,  31'h2000_0000,  1'b0, '{31'd0,          62'd0}},
    '{FIELD_MAX,      31'h7FFF_FFFE,  1'b0, '{31'd0,          62'd0}},
    '{31'd1836311903, 31'd1134903170, 1'b0, '{31'd0,          62'd0}},
    '{FIELD_MAX,      31'd2147483629, 1'b0, '{31'd0,          62'd0}},
    '{31'h5555_5555,  31'h2AAA_AAAA,  1'b0, '{31'd0,          62'd0}},
    '{31'd3072,       31'd7168,       1'b0, '{31'd0,          62'd0}},
    '{31'h7FFF_FFFE,  31'h3FFF_FFFF,  1'b0, '{31'd0,          62'd0}}
  };

  gcd_lcm_t results_due [$];
  gcd_lcm_t expected_word;
  int       fault_count;
  int       words_sent;
  int       cycles_run;
  bit       sender_idles;
  bit       receiver_idles;

  function automatic gcd_lcm_t compute_gcd_lcm(input logic [FIELD_BITS-1:0] first,
                                               input logic [FIELD_BITS-1:0] second);
    bit [63:0] mask;
    bit [63:0] a;
    bit [63:0] b;
    bit [63:0] x;
    bit [63:0] y;
    bit [63:0] r;
    bit [63:0] l;
    gcd_lcm_t  res;
    mask = (64'd1 << OPERAND_BITS) - 64'd1;
    a = 64'(first) & mask;
    b = 64'(second) & mask;
    x = a;
    y = b;
    while (y != 64'd0) begin
      r = x % y;
      x = y;
      y = r;
    end
    l = 64'd0;
    if (a != 64'd0 && b != 64'd0 && x != 64'd0) l = (a / x) * b;
    res.gcd_value = x[GCD_BITS-1:0];
    res.lcm_value = l[LCM_BITS-1:0];
    return res;
  endfunction

  function automatic void draw_operands(output logic [FIELD_BITS-1:0] first,
                                        output logic [FIELD_BITS-1:0] second);
    int unsigned  pick;
    int unsigned  g;
    bit [31:0]    t;
    bit [31:0]    u;
    operand_mix_t mix;
    pick = $urandom_range(0, 8);
    mix = (pick < 3) ? MIX_FULL : operand_mix_t'(pick - 2);
    t = $urandom;
    u = $urandom;
    case (mix)
      MIX_SHARED: begin
        g = $urandom_range(1, 65535);
        t = g * $urandom_range(1, 32767);
        u = g * $urandom_range(1, 32767);
      end
      MIX_TWOS: begin
        t = $urandom_range(1, 1023) << $urandom_range(0, 20);
        u = $urandom_range(1, 1023) << $urandom_range(0, 20);
      end
      MIX_SMALL: begin
        t = $urandom_range(0, 255);
        u = $urandom_range(0, 255);
      end
      MIX_ZERO: begin
        case ($urandom_range(0, 2))
          0: t = 32'd0;
          1: u = 32'd0;
          default: begin
            t = 32'd0;
            u = 32'd0;
          end
        endcase
      end
      MIX_EQUAL: u = t;
      MIX_MULTIPLE: begin
        t = $urandom_range(1, 65535);
        u = t * $urandom_range(1, 32767);
      end
      default: ;
    endcase
    first  = t[FIELD_BITS-1:0];
    second = u[FIELD_BITS-1:0];
  endfunction

  task automatic offer_word(input logic [FIELD_BITS-1:0] first,
                            input logic [FIELD_BITS-1:0] second,
                            input gcd_lcm_t              sums);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      operand_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    operand_ch.valid        <= 1'b1;
    operand_ch.first_value  <= first;
    operand_ch.second_value <= second;
    do @(posedge clk); while (!operand_ch.ready);
    results_due.push_back(sums);
    words_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles_run++;
    if (cycles_run >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // hold once for a long stretch, otherwise stall in short bursts
  initial begin
    int stall_left;
    int hold_left;
    bit hold_done;
    stall_left = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && words_sent >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("unexpected result word: gcd=%0d lcm=%0d",
                   result_ch.gcd_value, result_ch.lcm_value);
      end else begin
        expected_word = results_due.pop_front();
        if (result_ch.gcd_value !== expected_word.gcd_value ||
            result_ch.lcm_value !== expected_word.lcm_value) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT)
            $display("mismatch: gcd exp=%0d act=%0d, lcm exp=%0d act=%0d",
                     expected_word.gcd_value, result_ch.gcd_value,
                     expected_word.lcm_value, result_ch.lcm_value);
        end
      end
    end
  end

  initial begin
    logic [FIELD_BITS-1:0] first;
    logic [FIELD_BITS-1:0] second;
    gcd_lcm_t              sums;
    int                    drain;
    fault_count    = 0;
    words_sent     = 0;
    cycles_run     = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    rst = 1'b1;
    operand_ch.valid        = 1'b0;
    operand_ch.first_value  = '0;
    operand_ch.second_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      first  = directed_rows[i].first_value;
      second = directed_rows[i].second_value;
      sums   = directed_rows[i].typed_in ? directed_rows[i].sums
                                         : compute_gcd_lcm(first, second);
      offer_word(first, second, sums);
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n >= RANDOM_WORDS - CALM_WORDS) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end else if (n % MODE_SPAN == 0) begin
        sender_idles   = $urandom_range(0, 1);
        receiver_idles = $urandom_range(0, 1);
      end
      draw_operands(first, second);
      offer_word(first, second, compute_gcd_lcm(first, second));
    end
    operand_ch.valid <= 1'b0;

    drain = 0;
    while (results_due.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $display("%0d result words never arrived", results_due.size());
      fault_count += results_due.size();
    end

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
